// File: src/clcd4_pkg.sv
package clcd4_pkg;

    // Operation codes carried on s_tuser
    localparam logic [2:0] OP_CMD   = 3'd0;
    localparam logic [2:0] OP_DATA  = 3'd1;
    localparam logic [2:0] OP_POS   = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_INIT  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_PULSE_HALF = 3'd0;
    localparam logic [2:0] REG_POWER_ON   = 3'd1;
    localparam logic [2:0] REG_SETUP      = 3'd2;
    localparam logic [2:0] REG_CMD_NIB    = 3'd3;
    localparam logic [2:0] REG_DATA_NIB   = 3'd4;
    localparam logic [2:0] REG_CLEAR      = 3'd5;
    localparam logic [2:0] REG_INIT_GAP   = 3'd6;

    // Reset values of the configuration registers
    localparam logic [9:0]  RST_PULSE_HALF = 10'd45;
    localparam logic [20:0] RST_POWER_ON   = 21'd1600000;
    localparam logic [20:0] RST_SETUP      = 21'd4000;
    localparam logic [20:0] RST_CMD_NIB    = 21'd400000;
    localparam logic [20:0] RST_DATA_NIB   = 21'd16000;
    localparam logic [20:0] RST_CLEAR      = 21'd300000;
    localparam logic [20:0] RST_INIT_GAP   = 21'd4000;

    localparam int          HOLD_W    = 23;
    localparam logic [22:0] LONG_WAIT = 23'd4000000;

    // Microcode layout
    localparam int          PC_W        = 6;
    localparam logic [5:0]  ENTRY_BYTE  = 6'd0;
    localparam logic [5:0]  ENTRY_CLEAR = 6'd5;
    localparam logic [5:0]  ENTRY_INIT  = 6'd15;
    localparam logic [5:0]  LAST_ADDR   = 6'd38;

    // Nibble source
    localparam logic [1:0] NIB_HI    = 2'd0;
    localparam logic [1:0] NIB_LO    = 2'd1;
    localparam logic [1:0] NIB_CONST = 2'd2;

    // Wait term of the hold
    localparam logic [2:0] W_NONE  = 3'd0;
    localparam logic [2:0] W_SETUP = 3'd1;
    localparam logic [2:0] W_POWER = 3'd2;
    localparam logic [2:0] W_LONG  = 3'd3;
    localparam logic [2:0] W_CMD   = 3'd4;
    localparam logic [2:0] W_NIB   = 3'd5;

    // Tail term of the hold
    localparam logic [1:0] T_NONE  = 2'd0;
    localparam logic [1:0] T_CLEAR = 2'd1;
    localparam logic [1:0] T_GAP   = 2'd2;

    // One control word per step
    typedef struct packed {
        logic       en;
        logic [1:0] nib_sel;
        logic [3:0] nib_const;
        logic       add_pulse;
        logic [2:0] wait_sel;
        logic [1:0] tail_sel;
        logic       done;
    } uc_word_t;

    function automatic uc_word_t uc(input logic en, input logic [1:0] nsel,
                                    input logic [3:0] nconst, input logic addp,
                                    input logic [2:0] wsel, input logic [1:0] tsel,
                                    input logic done);
        uc_word_t w;
        w.en        = en;
        w.nib_sel   = nsel;
        w.nib_const = nconst;
        w.add_pulse = addp;
        w.wait_sel  = wsel;
        w.tail_sel  = tsel;
        w.done      = done;
        return w;
    endfunction

    // Program store: byte run, clear and home, init program
    function automatic uc_word_t uc_rom(input logic [5:0] addr);
        uc_word_t w;
        w = uc(1'b0, NIB_CONST, 4'h0, 1'b0, W_NONE, T_NONE, 1'b1);
        case (addr)
            // byte from the request register
            6'd0:  w = uc(1'b0, NIB_HI, 4'h0, 1'b0, W_SETUP, T_NONE, 1'b0);
            6'd1:  w = uc(1'b1, NIB_HI, 4'h0, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd2:  w = uc(1'b0, NIB_HI, 4'h0, 1'b1, W_NIB,   T_NONE, 1'b0);
            6'd3:  w = uc(1'b1, NIB_LO, 4'h0, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd4:  w = uc(1'b0, NIB_LO, 4'h0, 1'b1, W_NIB,   T_NONE, 1'b1);
            // clear: command 0x01
            6'd5:  w = uc(1'b0, NIB_CONST, 4'h0, 1'b0, W_SETUP, T_NONE, 1'b0);
            6'd6:  w = uc(1'b1, NIB_CONST, 4'h0, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd7:  w = uc(1'b0, NIB_CONST, 4'h0, 1'b1, W_NIB,   T_NONE, 1'b0);
            6'd8:  w = uc(1'b1, NIB_CONST, 4'h1, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd9:  w = uc(1'b0, NIB_CONST, 4'h1, 1'b1, W_NIB,   T_NONE, 1'b0);
            // home: command 0x02
            6'd10: w = uc(1'b0, NIB_CONST, 4'h0, 1'b0, W_SETUP, T_NONE,  1'b0);
            6'd11: w = uc(1'b1, NIB_CONST, 4'h0, 1'b1, W_NONE,  T_NONE,  1'b0);
            6'd12: w = uc(1'b0, NIB_CONST, 4'h0, 1'b1, W_NIB,   T_NONE,  1'b0);
            6'd13: w = uc(1'b1, NIB_CONST, 4'h2, 1'b1, W_NONE,  T_NONE,  1'b0);
            6'd14: w = uc(1'b0, NIB_CONST, 4'h2, 1'b1, W_NIB,   T_CLEAR, 1'b1);
            // init: power-on hold and four single nibbles
            6'd15: w = uc(1'b0, NIB_CONST, 4'h3, 1'b0, W_POWER, T_NONE, 1'b0);
            6'd16: w = uc(1'b1, NIB_CONST, 4'h3, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd17: w = uc(1'b0, NIB_CONST, 4'h3, 1'b1, W_LONG,  T_NONE, 1'b0);
            6'd18: w = uc(1'b1, NIB_CONST, 4'h3, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd19: w = uc(1'b0, NIB_CONST, 4'h3, 1'b1, W_POWER, T_NONE, 1'b0);
            6'd20: w = uc(1'b1, NIB_CONST, 4'h3, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd21: w = uc(1'b0, NIB_CONST, 4'h3, 1'b1, W_CMD,   T_NONE, 1'b0);
            6'd22: w = uc(1'b1, NIB_CONST, 4'h2, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd23: w = uc(1'b0, NIB_CONST, 4'h2, 1'b1, W_CMD,   T_NONE, 1'b0);
            // init: function set 0x28
            6'd24: w = uc(1'b0, NIB_CONST, 4'h2, 1'b0, W_SETUP, T_NONE, 1'b0);
            6'd25: w = uc(1'b1, NIB_CONST, 4'h2, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd26: w = uc(1'b0, NIB_CONST, 4'h2, 1'b1, W_NIB,   T_NONE, 1'b0);
            6'd27: w = uc(1'b1, NIB_CONST, 4'h8, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd28: w = uc(1'b0, NIB_CONST, 4'h8, 1'b1, W_NIB,   T_GAP,  1'b0);
            // init: display on 0x0F
            6'd29: w = uc(1'b0, NIB_CONST, 4'h0, 1'b0, W_SETUP, T_NONE, 1'b0);
            6'd30: w = uc(1'b1, NIB_CONST, 4'h0, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd31: w = uc(1'b0, NIB_CONST, 4'h0, 1'b1, W_NIB,   T_NONE, 1'b0);
            6'd32: w = uc(1'b1, NIB_CONST, 4'hF, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd33: w = uc(1'b0, NIB_CONST, 4'hF, 1'b1, W_NIB,   T_GAP,  1'b0);
            // init: entry mode 0x06
            6'd34: w = uc(1'b0, NIB_CONST, 4'h0, 1'b0, W_SETUP, T_NONE, 1'b0);
            6'd35: w = uc(1'b1, NIB_CONST, 4'h0, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd36: w = uc(1'b0, NIB_CONST, 4'h0, 1'b1, W_NIB,   T_NONE, 1'b0);
            6'd37: w = uc(1'b1, NIB_CONST, 4'h6, 1'b1, W_NONE,  T_NONE, 1'b0);
            6'd38: w = uc(1'b0, NIB_CONST, 4'h6, 1'b1, W_NIB,   T_GAP,  1'b1);
            default: w = uc(1'b0, NIB_CONST, 4'h0, 1'b0, W_NONE, T_NONE, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// File: src/char_lcd_four_bit_sequencer.sv
// The accepted request sets the step counter; its first step then loads the output register.
// Throughput: one pin-state word per cycle while m_tready is high; a byte request gives
// 5 words, clear and home 10, init 24; the next request is taken once the step counter
// has issued the last step of the current program (one step per cycle while not stalled).
// Reset (aresetn low, synchronous): sequencer idle, output empty, config at reset values.
module char_lcd_four_bit_sequencer #(
    parameter int COLUMNS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // byte_value[7:0], row[8], column[14:9], zero[15]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    // pin-state channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // reg_select[0], enable[1], data_nibble[5:2],
                                   // hold_cycles[28:6], zero[31:29]
    output logic        m_tlast,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [20:0] cfg_data
);

    localparam logic [5:0] COL_MAX = 6'(COLUMNS - 1);

    // configuration registers
    logic [9:0]  pulse_half_reg;
    logic [20:0] power_on_reg, setup_reg, cmd_nib_reg, data_nib_reg;
    logic [20:0] clear_extra_reg, init_gap_reg;

    // sequencer state
    logic                     busy_reg, busy_next;
    logic [clcd4_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                     rs_reg, rs_next;
    logic [7:0]               byte_reg, byte_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic                         m_rs_reg, m_en_reg, m_last_reg;
    logic [3:0]                   m_nib_reg;
    logic [clcd4_pkg::HOLD_W-1:0] m_hold_reg;

    clcd4_pkg::uc_word_t uw;
    logic       s_fire, step_en, op_known;
    logic [2:0] op;
    logic [7:0] in_byte;
    logic       in_row;
    logic [5:0] in_col, col_sat;
    logic [6:0] pos_addr;
    logic [3:0] nib_val;
    logic [clcd4_pkg::HOLD_W-1:0] base_val, wait_val, tail_val, hold_val;

    assign op      = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign in_row  = s_tdata[8];
    assign in_col  = s_tdata[14:9];

    assign s_tready  = !busy_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // step issues when the output register is free or being drained
    assign step_en = busy_reg && (!m_valid_reg || m_tready);
    assign uw      = clcd4_pkg::uc_rom(pc_reg);

    // set-position command byte
    assign col_sat  = (in_col > COL_MAX) ? COL_MAX : in_col;
    assign pos_addr = {in_row, 6'd0} + {1'b0, col_sat};

    // dispatch: entry point per operation
    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        rs_next   = rs_reg;
        byte_next = byte_reg;
        op_known  = 1'b1;
        if (step_en) begin
            pc_next = pc_reg + 1'b1;
            if (uw.done) begin
                busy_next = 1'b0;
            end
        end
        if (s_fire) begin
            rs_next   = (op == clcd4_pkg::OP_DATA);
            byte_next = in_byte;
            case (op)
                clcd4_pkg::OP_CMD, clcd4_pkg::OP_DATA: begin
                    pc_next = clcd4_pkg::ENTRY_BYTE;
                end
                clcd4_pkg::OP_POS: begin
                    pc_next   = clcd4_pkg::ENTRY_BYTE;
                    byte_next = {1'b1, pos_addr};
                end
                clcd4_pkg::OP_CLEAR: begin
                    pc_next = clcd4_pkg::ENTRY_CLEAR;
                end
                clcd4_pkg::OP_INIT: begin
                    pc_next = clcd4_pkg::ENTRY_INIT;
                end
                default: begin
                    op_known = 1'b0;
                end
            endcase
            busy_next = op_known;
        end
    end

    // datapath: nibble and hold of the current step
    always_comb begin
        case (uw.nib_sel)
            clcd4_pkg::NIB_HI: nib_val = byte_reg[7:4];
            clcd4_pkg::NIB_LO: nib_val = byte_reg[3:0];
            default:           nib_val = uw.nib_const;
        endcase
        base_val = uw.add_pulse ? clcd4_pkg::HOLD_W'(pulse_half_reg) : '0;
        case (uw.wait_sel)
            clcd4_pkg::W_SETUP: wait_val = clcd4_pkg::HOLD_W'(setup_reg);
            clcd4_pkg::W_POWER: wait_val = clcd4_pkg::HOLD_W'(power_on_reg);
            clcd4_pkg::W_LONG:  wait_val = clcd4_pkg::LONG_WAIT;
            clcd4_pkg::W_CMD:   wait_val = clcd4_pkg::HOLD_W'(cmd_nib_reg);
            clcd4_pkg::W_NIB:   wait_val = rs_reg ? clcd4_pkg::HOLD_W'(data_nib_reg)
                                                  : clcd4_pkg::HOLD_W'(cmd_nib_reg);
            default:            wait_val = '0;
        endcase
        case (uw.tail_sel)
            clcd4_pkg::T_CLEAR: tail_val = clcd4_pkg::HOLD_W'(clear_extra_reg);
            clcd4_pkg::T_GAP:   tail_val = clcd4_pkg::HOLD_W'(init_gap_reg);
            default:            tail_val = '0;
        endcase
        hold_val = base_val + wait_val + tail_val;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (step_en) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request and output payload
    always_ff @(posedge aclk) begin
        rs_reg   <= rs_next;
        byte_reg <= byte_next;
        if (step_en) begin
            m_rs_reg   <= rs_reg;
            m_en_reg   <= uw.en;
            m_nib_reg  <= nib_val;
            m_hold_reg <= hold_val;
            m_last_reg <= uw.done;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_half_reg  <= clcd4_pkg::RST_PULSE_HALF;
            power_on_reg    <= clcd4_pkg::RST_POWER_ON;
            setup_reg       <= clcd4_pkg::RST_SETUP;
            cmd_nib_reg     <= clcd4_pkg::RST_CMD_NIB;
            data_nib_reg    <= clcd4_pkg::RST_DATA_NIB;
            clear_extra_reg <= clcd4_pkg::RST_CLEAR;
            init_gap_reg    <= clcd4_pkg::RST_INIT_GAP;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                clcd4_pkg::REG_PULSE_HALF: pulse_half_reg  <= cfg_data[9:0];
                clcd4_pkg::REG_POWER_ON:   power_on_reg    <= cfg_data;
                clcd4_pkg::REG_SETUP:      setup_reg       <= cfg_data;
                clcd4_pkg::REG_CMD_NIB:    cmd_nib_reg     <= cfg_data;
                clcd4_pkg::REG_DATA_NIB:   data_nib_reg    <= cfg_data;
                clcd4_pkg::REG_CLEAR:      clear_extra_reg <= cfg_data;
                clcd4_pkg::REG_INIT_GAP:   init_gap_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_hold_reg, m_nib_reg, m_en_reg, m_rs_reg};

    // checks
    property p_pc_in_program;
        @(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (pc_reg <= clcd4_pkg::LAST_ADDR);
    endproperty
    a_pc_in_program: assert property (p_pc_in_program)
        else $error("step counter outside program");

    property p_known_op_starts;
        @(posedge aclk) disable iff (!aresetn)
        (s_fire && op_known) |=> busy_reg;
    endproperty
    a_known_op_starts: assert property (p_known_op_starts)
        else $error("accepted request did not start a program");

    property p_end_shows_last;
        @(posedge aclk) disable iff (!aresetn)
        ($fell(busy_reg) && $past(aresetn)) |-> (m_valid_reg && m_last_reg);
    endproperty
    a_end_shows_last: assert property (p_end_shows_last)
        else $error("program ended without a last word");

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy)
        else $error("request taken while a program runs");

endmodule

// File: sim/testbench.sv
module testbench;

    localparam int COLUMNS         = 40;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PER_MODE = 28;
    localparam int CONFIG_MODES    = 5;

    // Codes the block must ignore
    localparam logic [2:0] OP_RSVD_5  = 3'd5;
    localparam logic [2:0] OP_RSVD_6  = 3'd6;
    localparam logic [2:0] OP_RSVD_7  = 3'd7;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Panel command bytes and line levels
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [6:0] ROW1_OFFSET    = 7'h40;
    localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB   = 4'h2;
    localparam logic       RS_CMD         = 1'b0;
    localparam logic       RS_DATA        = 1'b1;
    localparam logic       EN_LOW         = 1'b0;
    localparam logic       EN_HIGH        = 1'b1;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nib;
        logic [22:0] hold;
        logic        last;
    } pin_word_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
        logic       typed;
        pin_word_t  first;
    } lcd_request_t;

    localparam logic [22:0] SETUP_RST_HOLD = {2'b0, clcd4_pkg::RST_SETUP};
    localparam logic [22:0] POWER_RST_HOLD = {2'b0, clcd4_pkg::RST_POWER_ON};
    localparam pin_word_t   NO_WORD        = '0;

    // Directed requests; first pin word typed in where it is obvious at reset values
    lcd_request_t directed_reqs [19] = '{
        '{clcd4_pkg::OP_CMD,   8'h00, 1'b0, 6'd0,  1'b1,
          '{RS_CMD,  EN_LOW, 4'h0, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_CMD,   8'hFF, 1'b0, 6'd0,  1'b1,
          '{RS_CMD,  EN_LOW, 4'hF, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_DATA,  8'h00, 1'b0, 6'd0,  1'b1,
          '{RS_DATA, EN_LOW, 4'h0, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_DATA,  8'hFF, 1'b1, 6'd63, 1'b1,
          '{RS_DATA, EN_LOW, 4'hF, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_DATA,  8'hA5, 1'b0, 6'd0,  1'b0, NO_WORD},
        '{clcd4_pkg::OP_CMD,   8'h5A, 1'b1, 6'd21, 1'b0, NO_WORD},
        '{clcd4_pkg::OP_POS,   8'h00, 1'b0, 6'd0,  1'b1,
          '{RS_CMD,  EN_LOW, 4'h8, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_POS,   8'hFF, 1'b1, 6'd39, 1'b1,
          '{RS_CMD,  EN_LOW, 4'hE, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_POS,   8'h00, 1'b1, 6'd63, 1'b1,
          '{RS_CMD,  EN_LOW, 4'hE, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_POS,   8'h00, 1'b0, 6'd40, 1'b1,
          '{RS_CMD,  EN_LOW, 4'hA, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_POS,   8'h00, 1'b0, 6'd32, 1'b0, NO_WORD},
        '{clcd4_pkg::OP_POS,   8'h00, 1'b1, 6'd31, 1'b0, NO_WORD},
        '{clcd4_pkg::OP_CLEAR, 8'h00, 1'b0, 6'd0,  1'b1,
          '{RS_CMD,  EN_LOW, 4'h0, SETUP_RST_HOLD, 1'b0}},
        '{clcd4_pkg::OP_INIT,  8'h00, 1'b0, 6'd0,  1'b1,
          '{RS_CMD,  EN_LOW, 4'h3, POWER_RST_HOLD, 1'b0}},
        '{OP_RSVD_5,           8'h12, 1'b0, 6'd5,  1'b0, NO_WORD},
        '{OP_RSVD_6,           8'hFF, 1'b1, 6'd63, 1'b0, NO_WORD},
        '{OP_RSVD_7,           8'h00, 1'b0, 6'd0,  1'b0, NO_WORD},
        '{clcd4_pkg::OP_CMD,   8'h3C, 1'b0, 6'd0,  1'b0, NO_WORD},
        '{clcd4_pkg::OP_DATA,  8'h80, 1'b0, 6'd0,  1'b0, NO_WORD}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // byte_value[7:0], row[8], column[14:9], zero[15]
    logic [2:0]  s_tuser;    // operation[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;    // reg_select[0], enable[1], data_nibble[5:2], hold_cycles[28:6]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [20:0] cfg_data;

    // Shadow of the configuration registers
    logic [9:0]  half_time  = clcd4_pkg::RST_PULSE_HALF;
    logic [20:0] power_wait = clcd4_pkg::RST_POWER_ON;
    logic [20:0] setup_hold = clcd4_pkg::RST_SETUP;
    logic [20:0] cmd_wait   = clcd4_pkg::RST_CMD_NIB;
    logic [20:0] data_wait  = clcd4_pkg::RST_DATA_NIB;
    logic [20:0] clear_wait = clcd4_pkg::RST_CLEAR;
    logic [20:0] init_gap   = clcd4_pkg::RST_INIT_GAP;

    pin_word_t expected_pins [$];
    logic      pending_typed;
    pin_word_t pending_first;
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    bit        steady = 1'b0;

    char_lcd_four_bit_sequencer #(.COLUMNS(COLUMNS)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one; none in steady mode
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    function automatic void push_pin_state(input logic rs, input logic en,
                                           input logic [3:0] nib, input logic [22:0] hold);
        pin_word_t w;
        w = '{rs, en, nib, hold, 1'b0};
        expected_pins.push_back(w);
    endfunction

    // Enable pulse on one nibble, extra wait folded into the low hold
    function automatic void push_pulse(input logic rs, input logic [3:0] nib,
                                       input logic [22:0] extra);
        push_pin_state(rs, EN_HIGH, nib, {13'd0, half_time});
        push_pin_state(rs, EN_LOW, nib, {13'd0, half_time} + extra);
    endfunction

    function automatic void push_byte(input logic rs, input logic [7:0] b,
                                      input logic [22:0] tail);
        logic [22:0] w;
        w = rs ? {2'b0, data_wait} : {2'b0, cmd_wait};
        push_pin_state(rs, EN_LOW, b[7:4], {2'b0, setup_hold});
        push_pulse(rs, b[7:4], w);
        push_pulse(rs, b[3:0], w + tail);
    endfunction

    // Pin words one request produces, appended to the expected list
    function automatic void predict_request(input logic [2:0] op, input logic [7:0] value,
                                            input logic row, input logic [5:0] col);
        int        n0;
        logic [6:0] addr;
        pin_word_t tail_word;
        n0 = expected_pins.size();
        case (op)
            clcd4_pkg::OP_CMD:  push_byte(RS_CMD, value, '0);
            clcd4_pkg::OP_DATA: push_byte(RS_DATA, value, '0);
            clcd4_pkg::OP_POS: begin
                addr = (col > COLUMNS - 1) ? 7'(COLUMNS - 1) : {1'b0, col};
                addr = addr + (row ? ROW1_OFFSET : 7'd0);
                push_byte(RS_CMD, CMD_SET_DDRAM | {1'b0, addr}, '0);
            end
            clcd4_pkg::OP_CLEAR: begin
                push_byte(RS_CMD, CMD_CLEAR, '0);
                push_byte(RS_CMD, CMD_HOME, {2'b0, clear_wait});
            end
            clcd4_pkg::OP_INIT: begin
                push_pin_state(RS_CMD, EN_LOW, WAKE_NIBBLE, {2'b0, power_wait});
                push_pulse(RS_CMD, WAKE_NIBBLE, clcd4_pkg::LONG_WAIT);
                push_pulse(RS_CMD, WAKE_NIBBLE, {2'b0, power_wait});
                push_pulse(RS_CMD, WAKE_NIBBLE, {2'b0, cmd_wait});
                push_pulse(RS_CMD, FOUR_BIT_NIB, {2'b0, cmd_wait});
                push_byte(RS_CMD, CMD_FUNC_SET, {2'b0, init_gap});
                push_byte(RS_CMD, CMD_DISPLAY_ON, {2'b0, init_gap});
                push_byte(RS_CMD, CMD_ENTRY_MODE, {2'b0, init_gap});
            end
            default: ;
        endcase
        if (expected_pins.size() > n0) begin
            tail_word = expected_pins[expected_pins.size() - 1];
            tail_word.last = 1'b1;
            expected_pins[expected_pins.size() - 1] = tail_word;
        end
    endfunction

    function automatic void apply_config(input logic [2:0] idx, input logic [20:0] val);
        case (idx)
            clcd4_pkg::REG_PULSE_HALF: half_time  = val[9:0];
            clcd4_pkg::REG_POWER_ON:   power_wait = val;
            clcd4_pkg::REG_SETUP:      setup_hold = val;
            clcd4_pkg::REG_CMD_NIB:    cmd_wait   = val;
            clcd4_pkg::REG_DATA_NIB:   data_wait  = val;
            clcd4_pkg::REG_CLEAR:      clear_wait = val;
            clcd4_pkg::REG_INIT_GAP:   init_gap   = val;
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [22:0] want,
                                        input logic [22:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Receiver: random stalls on m_tready
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Config shadow, prediction on accepted requests, checking of pin words, watchdog
    always @(posedge aclk) begin : monitor
        int        n0;
        pin_word_t got;
        pin_word_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                apply_config(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                n0 = expected_pins.size();
                predict_request(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[14:9]);
                if (pending_typed && expected_pins.size() > n0)
                    expected_pins[n0] = pending_first;
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[0], m_tdata[1], m_tdata[5:2], m_tdata[28:6], m_tlast};
                if (expected_pins.size() == 0) begin
                    $display("%0t: unexpected pin word %h, nothing expected", $time, got);
                    mismatches++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("reg_select", 23'(want.rs), 23'(got.rs));
                    check_field("enable", 23'(want.en), 23'(got.en));
                    check_field("data_nibble", 23'(want.nib), 23'(got.nib));
                    check_field("hold_cycles", want.hold, got.hold);
                    check_field("last", 23'(want.last), 23'(got.last));
                end
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_request(input lcd_request_t req);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tuser       <= req.op;
        s_tdata       <= {1'b0, req.col, req.row, req.value};
        pending_typed <= req.typed;
        pending_first <= req.first;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Wait for every expected word, then let the sequencer settle
    task automatic drain();
        while (expected_pins.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [20:0]  vals [7];
        lcd_request_t req;
        int           count;
        int           r;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = clcd4_pkg::OP_CMD;
        cfg_valid     = 1'b0;
        cfg_index     = clcd4_pkg::REG_PULSE_HALF;
        cfg_data      = '0;
        pending_typed = 1'b0;
        pending_first = NO_WORD;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset values
        foreach (directed_reqs[i])
            send_request(directed_reqs[i]);
        s_tvalid <= 1'b0;
        drain();

        // Random part across several register settings
        for (int mode = 0; mode < CONFIG_MODES; mode++) begin
            steady = (mode == 1);
            for (int i = 0; i < 7; i++) begin
                case (mode)
                    0: vals[i] = '0;
                    1: vals[i] = 21'h1FFFFF;
                    3: vals[i] = '0;
                    default: vals[i] = 21'($urandom);
                endcase
            end
            if (mode == 3) begin
                vals[clcd4_pkg::REG_PULSE_HALF] = {11'd0, clcd4_pkg::RST_PULSE_HALF};
                vals[clcd4_pkg::REG_POWER_ON]   = clcd4_pkg::RST_POWER_ON;
                vals[clcd4_pkg::REG_SETUP]      = clcd4_pkg::RST_SETUP;
                vals[clcd4_pkg::REG_CMD_NIB]    = clcd4_pkg::RST_CMD_NIB;
                vals[clcd4_pkg::REG_DATA_NIB]   = clcd4_pkg::RST_DATA_NIB;
                vals[clcd4_pkg::REG_CLEAR]      = clcd4_pkg::RST_CLEAR;
                vals[clcd4_pkg::REG_INIT_GAP]   = clcd4_pkg::RST_INIT_GAP;
            end
            for (int i = 0; i < 7; i++)
                write_reg(3'(i), vals[i]);
            if (mode == 2)
                write_reg(REG_UNUSED, 21'($urandom));
            cfg_valid <= 1'b0;

            count = 0;
            while (count < RANDOM_PER_MODE) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    req.op = clcd4_pkg::OP_INIT;
                else if (r < 12)
                    req.op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
                else
                    req.op = 3'($urandom_range(clcd4_pkg::OP_CMD, clcd4_pkg::OP_CLEAR));
                req.value = 8'($urandom);
                req.row   = 1'($urandom);
                req.col   = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 63))
                                                         : 6'($urandom_range(0, COLUMNS - 1));
                req.typed = 1'b0;
                req.first = NO_WORD;
                send_request(req);
                if (req.op <= clcd4_pkg::OP_INIT)
                    count++;
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && expected_pins.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: char_lcd_four_bit_sequencer.f
src/clcd4_pkg.sv
src/char_lcd_four_bit_sequencer.sv
sim/testbench.sv
